@@ rtl/ibp_pkg.sv @@
// Shared types, codes and coordinate mapping helpers for the border padding block.
`timescale 1ns / 1ps
`default_nettype none

package ibp_pkg;

	// Default frame store dimensions.
	localparam int DEF_MAX_ROWS = 512;
	localparam int DEF_MAX_COLS = 512;

	// Width of coordinate arithmetic: holds a padded frame size of up to three 10-bit terms
	// and a clamp limit of up to 4096.
	localparam int SW = 13;

	// Border modes.
	localparam logic [1:0] MODE_CONSTANT  = 2'd0;
	localparam logic [1:0] MODE_WRAP      = 2'd1;
	localparam logic [1:0] MODE_REFLECT   = 2'd2;
	localparam logic [1:0] MODE_REPLICATE = 2'd3;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_RANGE_ERR = 2'd1;
	localparam logic [1:0] STATUS_PAD_ERR   = 2'd2;

	// Operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] CFG_BORDER_MODE = 3'd0;
	localparam logic [2:0] CFG_PAD_TOP     = 3'd1;
	localparam logic [2:0] CFG_PAD_BOTTOM  = 3'd2;
	localparam logic [2:0] CFG_PAD_LEFT    = 3'd3;
	localparam logic [2:0] CFG_PAD_RIGHT   = 3'd4;
	localparam logic [2:0] CFG_IMAGE_ROWS  = 3'd5;
	localparam logic [2:0] CFG_IMAGE_COLS  = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic calc;
		logic addr;
		logic mem;
		logic out_pend;
	} ibp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic out_free;
	} ibp_sts_t;

	// One mapped axis coordinate.
	typedef struct packed {
		logic [SW-1:0] idx;
		logic          border;
	} ibp_map_t;

	// Effective image size: zero acts as one, anything above the store limit as the limit.
	function automatic logic [SW-1:0] clamp_size(input logic [9:0] v, input logic [SW-1:0] maxv);
		logic [SW-1:0] ext;
		ext = {{(SW-10){1'b0}}, v};
		if (ext == '0) begin
			return SW'(1);
		end
		return (ext > maxv) ? maxv : ext;
	endfunction

	// Map a padded-frame coordinate back into the source along one axis.
	function automatic ibp_map_t map_axis(input logic [SW-1:0] p, input logic [SW-1:0] lo,
			input logic [SW-1:0] n, input logic [1:0] mode);
		ibp_map_t r;
		logic [SW-1:0] d;
		logic [SW-1:0] e;
		d = lo - p;
		e = p - lo - n;
		r.border = 1'b0;
		r.idx = p - lo;
		if (p < lo) begin
			r.border = 1'b1;
			case (mode)
				MODE_WRAP:    r.idx = n - d;
				MODE_REFLECT: r.idx = d - SW'(1);
				default:      r.idx = '0;
			endcase
		end else if (p >= lo + n) begin
			r.border = 1'b1;
			case (mode)
				MODE_WRAP:    r.idx = e;
				MODE_REFLECT: r.idx = n - SW'(1) - e;
				default:      r.idx = n - SW'(1);
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ibp_ctrl.sv @@
// Controller state machine that sequences one word through map, address, memory and output steps.
`timescale 1ns / 1ps
`default_nettype none

module ibp_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire  ibp_pkg::ibp_sts_t sts,
	output ibp_pkg::ibp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_ADDR,
		ST_MEM,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic              ready_q;
	ibp_pkg::ibp_cmd_t cmd_q;

	assign s_axis_tready = ready_q;
	assign cmd = cmd_q;

	// State and registered commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
			cmd_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && ready_q) begin
						state_q <= ST_CALC;
						ready_q <= 1'b0;
						cmd_q <= '{calc: 1'b1, default: 1'b0};
					end else begin
						ready_q <= 1'b1;
						cmd_q <= '0;
					end
				end
				ST_CALC: begin
					state_q <= ST_ADDR;
					cmd_q <= '{addr: 1'b1, default: 1'b0};
				end
				ST_ADDR: begin
					state_q <= ST_MEM;
					cmd_q <= '{mem: 1'b1, default: 1'b0};
				end
				ST_MEM: begin
					if (sts.is_read) begin
						state_q <= ST_OUT;
						cmd_q <= '{out_pend: 1'b1, default: 1'b0};
					end else begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
						cmd_q <= '0;
					end
				end
				ST_OUT: begin
					// The datapath loads the output register in the cycle the slot is free.
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
						cmd_q <= '0;
					end else begin
						cmd_q <= '{out_pend: 1'b1, default: 1'b0};
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b0;
					cmd_q <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ibp_datapath.sv @@
// Datapath: configuration registers, coordinate mapping, frame store and output register.
`timescale 1ns / 1ps
`default_nettype none

module ibp_datapath #(
	parameter int MAX_ROWS = ibp_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = ibp_pkg::DEF_MAX_COLS
) (
	input  wire               clk,
	input  wire               arst_n,
	// Configuration writes
	input  wire               cfg_we,
	input  wire  [2:0]        cfg_index,
	input  wire  [9:0]        cfg_data,
	// Captured input word
	input  wire               in_take,
	input  wire  [31:0]       in_tdata,
	input  wire  [0:0]        in_tuser,
	// Controller link
	input  wire  ibp_pkg::ibp_cmd_t cmd,
	output ibp_pkg::ibp_sts_t sts,
	// Output channel
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [7:0]        m_axis_tdata,
	output logic [2:0]        m_axis_tuser
);

	localparam int SW = ibp_pkg::SW;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers.
	logic [1:0] border_mode_q;
	logic [9:0] pad_top_q;
	logic [9:0] pad_bottom_q;
	logic [9:0] pad_left_q;
	logic [9:0] pad_right_q;
	logic [9:0] image_rows_q;
	logic [9:0] image_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_mode_q <= ibp_pkg::MODE_CONSTANT;
			pad_top_q <= '0;
			pad_bottom_q <= '0;
			pad_left_q <= '0;
			pad_right_q <= '0;
			image_rows_q <= 10'd1;
			image_cols_q <= 10'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ibp_pkg::CFG_BORDER_MODE: border_mode_q <= cfg_data[1:0];
				ibp_pkg::CFG_PAD_TOP:     pad_top_q <= cfg_data;
				ibp_pkg::CFG_PAD_BOTTOM:  pad_bottom_q <= cfg_data;
				ibp_pkg::CFG_PAD_LEFT:    pad_left_q <= cfg_data;
				ibp_pkg::CFG_PAD_RIGHT:   pad_right_q <= cfg_data;
				ibp_pkg::CFG_IMAGE_ROWS:  image_rows_q <= cfg_data;
				ibp_pkg::CFG_IMAGE_COLS:  image_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input word capture.
	logic        op_q;
	logic [10:0] row_q;
	logic [10:0] col_q;
	logic [7:0]  pix_in_q;

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q <= in_tuser[0];
			row_q <= in_tdata[10:0];
			col_q <= in_tdata[21:11];
			pix_in_q <= in_tdata[29:22];
		end
	end

	// Mapping step: status, border flag and source coordinate.
	logic [SW-1:0]     nr;
	logic [SW-1:0]     nc;
	logic [SW-1:0]     row_x;
	logic [SW-1:0]     col_x;
	logic [SW-1:0]     ptop_x;
	logic [SW-1:0]     pbot_x;
	logic [SW-1:0]     plft_x;
	logic [SW-1:0]     prgt_x;
	logic              pad_err;
	logic              range_err;
	ibp_pkg::ibp_map_t mr;
	ibp_pkg::ibp_map_t mc;
	logic              any_border;

	always_comb begin
		nr = ibp_pkg::clamp_size(image_rows_q, SW'(MAX_ROWS));
		nc = ibp_pkg::clamp_size(image_cols_q, SW'(MAX_COLS));
		row_x = {{(SW-11){1'b0}}, row_q};
		col_x = {{(SW-11){1'b0}}, col_q};
		ptop_x = {{(SW-10){1'b0}}, pad_top_q};
		pbot_x = {{(SW-10){1'b0}}, pad_bottom_q};
		plft_x = {{(SW-10){1'b0}}, pad_left_q};
		prgt_x = {{(SW-10){1'b0}}, pad_right_q};
		pad_err = (border_mode_q == ibp_pkg::MODE_WRAP ||
				border_mode_q == ibp_pkg::MODE_REFLECT) &&
				(ptop_x > nr || pbot_x > nr || plft_x > nc || prgt_x > nc);
		range_err = (row_x >= ptop_x + nr + pbot_x) || (col_x >= plft_x + nc + prgt_x);
		mr = ibp_pkg::map_axis(row_x, ptop_x, nr, border_mode_q);
		mc = ibp_pkg::map_axis(col_x, plft_x, nc, border_mode_q);
		any_border = mr.border | mc.border;
	end

	logic [SW-1:0] sr_q;
	logic [SW-1:0] sc_q;
	logic          hit_q;
	logic          border_calc_q;
	logic [1:0]    status_calc_q;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			if (op_q == ibp_pkg::OP_LOAD) begin
				// A load outside the effective image is dropped.
				sr_q <= row_x;
				sc_q <= col_x;
				hit_q <= (row_x < nr) && (col_x < nc);
				border_calc_q <= 1'b0;
				status_calc_q <= ibp_pkg::STATUS_OK;
			end else begin
				sr_q <= mr.idx;
				sc_q <= mc.idx;
				hit_q <= !pad_err && !range_err &&
						!(any_border && border_mode_q == ibp_pkg::MODE_CONSTANT) &&
						(mr.idx < nr) && (mc.idx < nc);
				border_calc_q <= !pad_err && !range_err && any_border;
				if (pad_err) begin
					status_calc_q <= ibp_pkg::STATUS_PAD_ERR;
				end else if (range_err) begin
					status_calc_q <= ibp_pkg::STATUS_RANGE_ERR;
				end else begin
					status_calc_q <= ibp_pkg::STATUS_OK;
				end
			end
		end
	end

	// Address step: linear store address, row times the store width plus column.
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			addr_q <= AW'(sr_q[RW-1:0]) * AW'(MAX_COLS) + AW'(sc_q[CW-1:0]);
		end
	end

	// Frame store: one write or one registered read per word.
	logic [7:0] frame_mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.mem) begin
			if (op_q == ibp_pkg::OP_READ) begin
				rd_q <= frame_mem[addr_q];
			end else if (hit_q) begin
				frame_mem[addr_q] <= pix_in_q;
			end
		end
	end

	// Output register, loaded when the slot is empty or being drained.
	logic       out_free;
	logic       out_load;
	logic       m_valid_q;
	logic [7:0] pix_out_q;
	logic       border_out_q;
	logic [1:0] status_out_q;

	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = cmd.out_pend && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_out_q <= hit_q ? rd_q : 8'd0;
			border_out_q <= border_calc_q;
			status_out_q <= status_calc_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = pix_out_q;
	assign m_axis_tuser = {status_out_q, border_out_q};

	assign sts.is_read = op_q;
	assign sts.out_free = out_free;

endmodule

`default_nettype wire

@@ rtl/image_border_padding.sv @@
// Top level of the image border padding block: controller plus datapath.
//
// Input stream: each word is a load (tuser op = 0) that writes one source pixel at
// row/col, or a read (op = 1) that names a padded-frame row/col. A load gives no
// result word; a read gives exactly one result word with the mapped pixel, a border
// flag and a status (ok, coordinate outside padded frame, pad too wide for mode).
// The configuration channel writes border mode, the four pads and the image size;
// it is always ready and is meant to be written while no word is in flight.
// Timing: a word steps through map, address and frame-store stages one per cycle.
// A load frees the input again once its store step is done; a read frees it once
// its result is in the output register. The block takes no new word before the
// last one is through, as the single-port frame store and the serial controller
// work on one word at a time.
// When the receiver stalls, the result waits in the output register and the block
// holds the next read in its last step until the register frees.
// Reset clears the controller, the output valid and the registers to mode constant,
// zero pads and a 1 x 1 image; the frame store is not cleared and holds garbage
// until written.
`timescale 1ns / 1ps
`default_nettype none

module image_border_padding #(
	parameter int MAX_ROWS = ibp_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = ibp_pkg::DEF_MAX_COLS
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [9:0]  cfg_data,
	// Input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // row[10:0], col[21:11], pixel_in[29:22], zero pad
	input  wire  [0:0]  s_axis_tuser,   // op[0]
	// Result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // pixel_out[7:0]
	output logic [2:0]  m_axis_tuser    // in_border[0], status[2:1]
);

	ibp_pkg::ibp_cmd_t cmd;
	ibp_pkg::ibp_sts_t sts;

	assign cfg_ready = 1'b1;

	ibp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	ibp_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_take       (s_axis_tvalid && s_axis_tready),
		.in_tdata      (s_axis_tdata),
		.in_tuser      (s_axis_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

@@ rtl/ibp_checker.sv @@
// Port-level checker for the border padding block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ibp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [7:0]  m_axis_tdata,
	input wire [2:0]  m_axis_tuser
);

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// An error result carries a zero pixel and no border flag.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:1] != ibp_pkg::STATUS_OK |->
		m_axis_tdata == 8'd0 && !m_axis_tuser[0])
		else $error("error result with nonzero pixel or border flag");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:1] == ibp_pkg::STATUS_OK ||
		m_axis_tuser[2:1] == ibp_pkg::STATUS_RANGE_ERR ||
		m_axis_tuser[2:1] == ibp_pkg::STATUS_PAD_ERR)
		else $error("undefined status code");

	// The block works on one word at a time: ready drops right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a word is in flight");

endmodule

bind image_border_padding ibp_checker u_ibp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ verif/ibp_padding_checker.sv @@
// Checker for the image border padding block: predicts every read result and compares it.
`timescale 1ns / 1ps

module ibp_padding_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	input  wire        cfg_ready,
	input  wire [2:0]  cfg_index,
	input  wire [9:0]  cfg_data,
	input  wire        s_axis_tvalid,
	input  wire        s_axis_tready,
	input  wire [31:0] s_axis_tdata,   // row[10:0], col[21:11], pixel_in[29:22], zero pad
	input  wire [0:0]  s_axis_tuser,   // op[0]
	input  wire        m_axis_tvalid,
	input  wire        m_axis_tready,
	input  wire [7:0]  m_axis_tdata,   // pixel_out[7:0]
	input  wire [2:0]  m_axis_tuser,   // in_border[0], status[2:1]
	output int         mismatches,
	output int         outstanding
);

	localparam int STORE_ROWS = ibp_pkg::DEF_MAX_ROWS;
	localparam int STORE_COLS = ibp_pkg::DEF_MAX_COLS;

	typedef struct packed {
		logic [7:0] pixel;
		logic       border;
		logic [1:0] status;
	} read_result_t;

	// Local copy of the source image and of the configuration registers.
	logic [7:0]   source_pixels [STORE_ROWS * STORE_COLS];
	logic [1:0]   mode_q;
	logic [9:0]   top_q;
	logic [9:0]   bottom_q;
	logic [9:0]   left_q;
	logic [9:0]   right_q;
	logic [9:0]   rows_q;
	logic [9:0]   cols_q;
	read_result_t awaited_reads [$];

	// Size actually used for the image: zero means one, oversize means the store limit.
	function automatic int active_extent(input logic [9:0] v, input int limit);
		if (v == '0) begin
			return 1;
		end
		return (int'(v) > limit) ? limit : int'(v);
	endfunction

	// Fold one padded coordinate back onto the source axis and flag padding hits.
	function automatic int fold_to_source(input int p, input int lo, input int n,
			output bit padded);
		padded = 1'b0;
		if (p < lo) begin
			padded = 1'b1;
			case (mode_q)
				ibp_pkg::MODE_WRAP:    return n - (lo - p);
				ibp_pkg::MODE_REFLECT: return lo - p - 1;
				default:               return 0;
			endcase
		end
		if (p >= lo + n) begin
			padded = 1'b1;
			case (mode_q)
				ibp_pkg::MODE_WRAP:    return p - lo - n;
				ibp_pkg::MODE_REFLECT: return 2 * n - 1 - (p - lo);
				default:               return n - 1;
			endcase
		end
		return p - lo;
	endfunction

	// Expected result of a read at padded coordinate (r, c) under the current setup.
	function automatic read_result_t padded_pixel(input int r, input int c);
		read_result_t res;
		int nr;
		int nc;
		int sr;
		int sc;
		bit pad_r;
		bit pad_c;
		res = '0;
		nr = active_extent(rows_q, STORE_ROWS);
		nc = active_extent(cols_q, STORE_COLS);
		if ((mode_q == ibp_pkg::MODE_WRAP || mode_q == ibp_pkg::MODE_REFLECT) &&
				(int'(top_q) > nr || int'(bottom_q) > nr ||
				int'(left_q) > nc || int'(right_q) > nc)) begin
			res.status = ibp_pkg::STATUS_PAD_ERR;
		end else if (r >= int'(top_q) + nr + int'(bottom_q) ||
				c >= int'(left_q) + nc + int'(right_q)) begin
			res.status = ibp_pkg::STATUS_RANGE_ERR;
		end else begin
			sr = fold_to_source(r, int'(top_q), nr, pad_r);
			sc = fold_to_source(c, int'(left_q), nc, pad_c);
			res.status = ibp_pkg::STATUS_OK;
			res.border = pad_r | pad_c;
			// In constant mode the padding reads as zero without touching the store.
			if (!(res.border && mode_q == ibp_pkg::MODE_CONSTANT)) begin
				res.pixel = source_pixels[sr * STORE_COLS + sc];
			end
		end
		return res;
	endfunction

	// Report one differing result field and count it.
	function automatic int field_differs(input string name, input int want, input int got);
		$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		read_result_t got;
		read_result_t want;
		int row_in;
		int col_in;
		if (!arst_n) begin
			mode_q = ibp_pkg::MODE_CONSTANT;
			top_q = '0;
			bottom_q = '0;
			left_q = '0;
			right_q = '0;
			rows_q = 10'd1;
			cols_q = 10'd1;
			awaited_reads.delete();
			mismatches = 0;
		end else begin
			// Result word: compare with the oldest awaited read.
			if (m_axis_tvalid && m_axis_tready) begin
				got.pixel = m_axis_tdata;
				got.border = m_axis_tuser[0];
				got.status = m_axis_tuser[2:1];
				if (awaited_reads.size() == 0) begin
					$display("%0t: result word with no read waiting: pixel %0d border %0d status %0d",
						$time, got.pixel, got.border, got.status);
					mismatches++;
				end else begin
					want = awaited_reads.pop_front();
					if (got.pixel !== want.pixel) begin
						mismatches += field_differs("pixel_out", want.pixel, got.pixel);
					end
					if (got.border !== want.border) begin
						mismatches += field_differs("in_border", want.border, got.border);
					end
					if (got.status !== want.status) begin
						mismatches += field_differs("status", want.status, got.status);
					end
				end
			end

			// Input word: a read awaits a result, a load inside the image updates the store.
			if (s_axis_tvalid && s_axis_tready) begin
				row_in = int'(s_axis_tdata[10:0]);
				col_in = int'(s_axis_tdata[21:11]);
				if (s_axis_tuser[0] == ibp_pkg::OP_READ) begin
					awaited_reads.push_back(padded_pixel(row_in, col_in));
				end else if (row_in < active_extent(rows_q, STORE_ROWS) &&
						col_in < active_extent(cols_q, STORE_COLS)) begin
					source_pixels[row_in * STORE_COLS + col_in] = s_axis_tdata[29:22];
				end
			end

			// Register write.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ibp_pkg::CFG_BORDER_MODE: mode_q = cfg_data[1:0];
					ibp_pkg::CFG_PAD_TOP:     top_q = cfg_data;
					ibp_pkg::CFG_PAD_BOTTOM:  bottom_q = cfg_data;
					ibp_pkg::CFG_PAD_LEFT:    left_q = cfg_data;
					ibp_pkg::CFG_PAD_RIGHT:   right_q = cfg_data;
					ibp_pkg::CFG_IMAGE_ROWS:  rows_q = cfg_data;
					ibp_pkg::CFG_IMAGE_COLS:  cols_q = cfg_data;
					default: ;
				endcase
			end
		end
		outstanding = awaited_reads.size();
	end

endmodule

@@ verif/tb_image_border_padding.sv @@
// Top of the border padding testbench: drives loads, reads and register setups and gives the verdict.
`timescale 1ns / 1ps

module tb_image_border_padding;

	localparam int CLK_PERIOD   = 4;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int COORD_MAX    = 1535;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = ibp_pkg::CFG_BORDER_MODE;
	logic [9:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // row[10:0], col[21:11], pixel_in[29:22], zero pad
	logic [0:0]  s_axis_tuser = '0;   // op[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // pixel_out[7:0]
	logic [2:0]  m_axis_tuser;        // in_border[0], status[2:1]

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	image_border_padding dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	ibp_padding_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Free-running clock.
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result receiver: changing stall patterns, plus one long hold-off on request.
	initial begin : result_sink
		int run_left;
		int style;
		int held;
		run_left = 0;
		style = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				held++;
				if (held >= HOLD_CYCLES) begin
					hold_done = 1'b1;
				end
			end else begin
				if (run_left == 0) begin
					style = $urandom_range(0, 3);
					run_left = $urandom_range(10, 150);
				end
				run_left--;
				case (style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (run_left % 3 != 0);
				endcase
			end
		end
	end

	// Effective image size as the block sees it.
	function automatic int eff_size(input int v, input int limit);
		return (v == 0) ? 1 : ((v > limit) ? limit : v);
	endfunction

	// Pad size mostly within the image, now and then too wide for wrap or reflect.
	function automatic int pad_draw(input int extent);
		return $urandom_range(0, extent + (($urandom_range(0, 9) == 0) ? 2 : 0));
	endfunction

	// Offer one word in bursts with random gaps and wait until it is taken.
	task automatic put_word(input logic op, input logic [10:0] r, input logic [10:0] c,
			input logic [7:0] pix);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, pix, c, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Write one register; valid stays high for a following write.
	task automatic write_reg(input logic [2:0] index, input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Stop offering words, wait for every awaited result, then let the pipeline drain.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One setup: program the registers, optionally fill the image, then random traffic.
	task automatic run_phase(input logic [1:0] mode, input int pt, input int pb,
			input int pl, input int pr, input int rows, input int cols,
			input int words, input bit fill, input bit squeeze);
		int nr;
		int nc;
		int fr;
		int fc;
		int r;
		int c;
		int k;
		settle();
		write_reg(ibp_pkg::CFG_BORDER_MODE, 10'(mode));
		write_reg(ibp_pkg::CFG_PAD_TOP, 10'(pt));
		write_reg(ibp_pkg::CFG_PAD_BOTTOM, 10'(pb));
		write_reg(ibp_pkg::CFG_PAD_LEFT, 10'(pl));
		write_reg(ibp_pkg::CFG_PAD_RIGHT, 10'(pr));
		write_reg(ibp_pkg::CFG_IMAGE_ROWS, 10'(rows));
		write_reg(ibp_pkg::CFG_IMAGE_COLS, 10'(cols));
		cfg_valid <= 1'b0;
		nr = eff_size(rows, ibp_pkg::DEF_MAX_ROWS);
		nc = eff_size(cols, ibp_pkg::DEF_MAX_COLS);
		fr = pt + nr + pb;
		fc = pl + nc + pr;

		// Write the whole image so that no later read lands on an unwritten pixel.
		if (fill) begin
			for (r = 0; r < nr; r++) begin
				for (c = 0; c < nc; c++) begin
					put_word(ibp_pkg::OP_LOAD, 11'(r), 11'(c), 8'($urandom_range(0, 255)));
				end
			end
		end

		if (squeeze) begin
			hold_req = 1'b1;
		end

		// Mostly reads inside the padded frame, some anywhere; loads mostly rewrite pixels.
		for (k = 0; k < words; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					r = $urandom_range(0, COORD_MAX);
					c = $urandom_range(0, COORD_MAX);
				end else begin
					r = $urandom_range(0, nr - 1);
					c = $urandom_range(0, nc - 1);
				end
				put_word(ibp_pkg::OP_LOAD, 11'(r), 11'(c), 8'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 7) == 0 || fr > COORD_MAX + 1 || fc > COORD_MAX + 1) begin
					r = $urandom_range(0, COORD_MAX);
					c = $urandom_range(0, COORD_MAX);
				end else begin
					r = $urandom_range(0, fr - 1);
					c = $urandom_range(0, fc - 1);
				end
				put_word(ibp_pkg::OP_READ, 11'(r), 11'(c), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin : stimulus
		int i;
		int rows;
		int cols;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setup: a 1 x 1 image in constant mode with no padding.
		put_word(ibp_pkg::OP_LOAD, 11'd0, 11'd0, 8'hFF);
		put_word(ibp_pkg::OP_LOAD, 11'(COORD_MAX), 11'(COORD_MAX), 8'h00);
		put_word(ibp_pkg::OP_READ, 11'd0, 11'd0, 8'h00);
		put_word(ibp_pkg::OP_READ, 11'd0, 11'd1, 8'hFF);
		put_word(ibp_pkg::OP_READ, 11'd1, 11'd0, 8'h00);
		put_word(ibp_pkg::OP_READ, 11'(COORD_MAX), 11'(COORD_MAX), 8'hFF);
		put_word(ibp_pkg::OP_LOAD, 11'd0, 11'd0, 8'h00);
		put_word(ibp_pkg::OP_READ, 11'd0, 11'd0, 8'h00);

		// Fixed setups: every mode, pads of zero and of the full size, both pad errors,
		// and image sizes of zero and above the store limit.
		run_phase(ibp_pkg::MODE_REPLICATE, 1, 1, 1, 1, 2, 2, 60, 1'b1, 1'b1);
		run_phase(ibp_pkg::MODE_CONSTANT, 512, 512, 0, 0, 512, 1, 80, 1'b1, 1'b0);
		run_phase(ibp_pkg::MODE_REFLECT, 512, 512, 0, 0, 512, 1, 80, 1'b0, 1'b0);
		run_phase(ibp_pkg::MODE_WRAP, 512, 512, 512, 512, 512, 1, 40, 1'b0, 1'b0);
		run_phase(ibp_pkg::MODE_REPLICATE, 0, 0, 512, 512, 1, 512, 80, 1'b1, 1'b0);
		run_phase(ibp_pkg::MODE_WRAP, 1, 1, 512, 512, 1, 512, 80, 1'b0, 1'b0);
		run_phase(ibp_pkg::MODE_CONSTANT, 0, 0, 0, 0, 0, 0, 40, 1'b1, 1'b0);
		run_phase(ibp_pkg::MODE_REFLECT, 3, 0, 0, 0, 2, 5, 40, 1'b0, 1'b0);
		run_phase(ibp_pkg::MODE_REPLICATE, 2, 3, 4, 1, 1023, 1, 60, 1'b0, 1'b0);
		run_phase(ibp_pkg::MODE_WRAP, 1, 1, 2, 2, 1, 1023, 60, 1'b0, 1'b0);

		// Random small images with random modes and pads.
		for (i = 0; i < 4; i++) begin
			rows = $urandom_range(1, 10);
			cols = $urandom_range(1, 10);
			run_phase(2'($urandom_range(0, 3)), pad_draw(rows), pad_draw(rows),
				pad_draw(cols), pad_draw(cols), rows, cols, 25, 1'b1, 1'b0);
		end

		settle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
